[src/apumix_pkg.sv]
package apumix_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_BPS - 1) / DIV_BPS;
    localparam int LATENCY    = DIV_STAGES + 4;

    localparam int LVL_W  = 4;
    localparam int DMC_W  = 7;
    localparam int PSUM_W = 5;
    localparam int OUT_W  = 16;

    localparam int PN_W  = 19;
    localparam int PD_W  = 21;
    localparam int ACC_W = 35;
    localparam int TN_W  = 49;

    localparam int RND_SH = FRAC_BITS - OUT_W;
    localparam int EXT_W  = FRAC_BITS + 2;

    localparam logic [PN_W-1:0]  PULSE_GAIN     = PN_W'(9588);
    localparam logic [PD_W-1:0]  PULSE_DEN_BASE = PD_W'(812800);
    localparam logic [PD_W-1:0]  PULSE_DEN_STEP = PD_W'(10000);

    localparam logic [ACC_W-1:0] TRI_WEIGHT   = ACC_W'(64'd277111758);
    localparam logic [ACC_W-1:0] NOISE_WEIGHT = ACC_W'(64'd186242826);
    localparam logic [ACC_W-1:0] DMC_WEIGHT   = ACC_W'(64'd100706707);

    localparam logic [TN_W-1:0]  TND_GAIN     = TN_W'(64'd15979);
    localparam logic [TN_W-1:0]  TND_DEN_BASE = TN_W'(64'd227979843306600);
    localparam logic [TN_W-1:0]  TND_DEN_STEP = TN_W'(64'd10000);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

endpackage

[src/apumix_div.sv]
module apumix_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [apumix_pkg::PD_W-1:0]     i_p_num,
    input  logic [apumix_pkg::PD_W-1:0]     i_p_den,
    input  logic [apumix_pkg::TN_W-1:0]     i_t_num,
    input  logic [apumix_pkg::TN_W-1:0]     i_t_den,
    output logic                            o_vld,
    output logic [apumix_pkg::FRAC_BITS-1:0] o_p_quo,
    output logic [apumix_pkg::FRAC_BITS-1:0] o_t_quo
);
    import apumix_pkg::*;

    logic                 r_vld   [DIV_STAGES];
    logic [PD_W-1:0]      r_p_rem [DIV_STAGES];
    logic [PD_W-1:0]      r_p_den [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_p_quo [DIV_STAGES];
    logic [TN_W-1:0]      r_t_rem [DIV_STAGES];
    logic [TN_W-1:0]      r_t_den [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_t_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                 in_vld;
        logic [PD_W-1:0]      in_p_rem;
        logic [PD_W-1:0]      in_p_den;
        logic [FRAC_BITS-1:0] in_p_quo;
        logic [TN_W-1:0]      in_t_rem;
        logic [TN_W-1:0]      in_t_den;
        logic [FRAC_BITS-1:0] in_t_quo;
        logic [PD_W-1:0]      n_p_rem;
        logic [FRAC_BITS-1:0] n_p_quo;
        logic [TN_W-1:0]      n_t_rem;
        logic [FRAC_BITS-1:0] n_t_quo;
        logic [PD_W:0]        p_sh;
        logic [TN_W:0]        t_sh;

        if (k == 0) begin : g_head
            assign in_vld   = i_vld;
            assign in_p_rem = i_p_num;
            assign in_p_den = i_p_den;
            assign in_p_quo = '0;
            assign in_t_rem = i_t_num;
            assign in_t_den = i_t_den;
            assign in_t_quo = '0;
        end else begin : g_body
            assign in_vld   = r_vld[k-1];
            assign in_p_rem = r_p_rem[k-1];
            assign in_p_den = r_p_den[k-1];
            assign in_p_quo = r_p_quo[k-1];
            assign in_t_rem = r_t_rem[k-1];
            assign in_t_den = r_t_den[k-1];
            assign in_t_quo = r_t_quo[k-1];
        end

        // Restoring division, DIV_BPS quotient bits per stage.
        always_comb begin
            n_p_rem = in_p_rem;
            n_p_quo = in_p_quo;
            n_t_rem = in_t_rem;
            n_t_quo = in_t_quo;
            p_sh    = '0;
            t_sh    = '0;
            for (int j = 0; j < DIV_BPS; j++) begin
                if (k * DIV_BPS + j < FRAC_BITS) begin
                    p_sh = {n_p_rem, 1'b0};
                    if (p_sh >= {1'b0, in_p_den}) begin
                        p_sh    = p_sh - {1'b0, in_p_den};
                        n_p_quo = {n_p_quo[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        n_p_quo = {n_p_quo[FRAC_BITS-2:0], 1'b0};
                    end
                    n_p_rem = p_sh[PD_W-1:0];

                    t_sh = {n_t_rem, 1'b0};
                    if (t_sh >= {1'b0, in_t_den}) begin
                        t_sh    = t_sh - {1'b0, in_t_den};
                        n_t_quo = {n_t_quo[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        n_t_quo = {n_t_quo[FRAC_BITS-2:0], 1'b0};
                    end
                    n_t_rem = t_sh[TN_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_p_rem[k] <= n_p_rem;
            r_p_den[k] <= in_p_den;
            r_p_quo[k] <= n_p_quo;
            r_t_rem[k] <= n_t_rem;
            r_t_den[k] <= in_t_den;
            r_t_quo[k] <= n_t_quo;
        end
    end

    assign o_vld   = r_vld[DIV_STAGES-1];
    assign o_p_quo = r_p_quo[DIV_STAGES-1];
    assign o_t_quo = r_t_quo[DIV_STAGES-1];

endmodule

[src/apu_nonlinear_mixer.sv]
// Nonlinear audio mixer: a word of five channel levels is taken at every clock edge where
// i_start is high, and its mix appears on o_mixed_level with o_done high for one cycle,
// once the word has passed registers r1 to r3, the divider stages and the output register.
// o_busy is never set, so one word can enter in every cycle; the two restoring dividers
// each resolve two quotient bits per stage. Results cannot be held off and
// must be taken in the cycle they are shown. The output is an unsigned Q0.16 fraction of
// full scale, rounded to nearest and saturated at 65535.
module apu_nonlinear_mixer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [apumix_pkg::LVL_W-1:0]      i_pulse_one_level,
    input  logic [apumix_pkg::LVL_W-1:0]      i_pulse_two_level,
    input  logic [apumix_pkg::LVL_W-1:0]      i_triangle_level,
    input  logic [apumix_pkg::LVL_W-1:0]      i_noise_level,
    input  logic [apumix_pkg::DMC_W-1:0]      i_sample_channel_level,
    output logic                              o_done,
    output logic [apumix_pkg::OUT_W-1:0]      o_mixed_level
);
    import apumix_pkg::*;

    localparam logic [EXT_W-1:0] RND_HALF = (EXT_W'(1) << RND_SH) >> 1;

    logic             r1_vld;
    logic [PN_W-1:0]  r1_p_num;
    logic [PD_W-1:0]  r1_p_den;
    logic [ACC_W-1:0] r1_tri;
    logic [ACC_W-1:0] r1_noise;
    logic [ACC_W-1:0] r1_dmc;

    logic             r2_vld;
    logic [PN_W-1:0]  r2_p_num;
    logic [PD_W-1:0]  r2_p_den;
    logic [ACC_W-1:0] r2_acc;

    logic             r3_vld;
    logic [PN_W-1:0]  r3_p_num;
    logic [PD_W-1:0]  r3_p_den;
    logic [TN_W-1:0]  r3_t_num;
    logic [TN_W-1:0]  r3_t_den;

    logic [PSUM_W-1:0]    pulse_sum;
    logic                 div_vld;
    logic [FRAC_BITS-1:0] p_quo;
    logic [FRAC_BITS-1:0] t_quo;
    logic [EXT_W-1:0]     rnd;
    logic [EXT_W-RND_SH-1:0] lvl;
    logic [OUT_W-1:0]     n_level;

    logic             r_done;
    logic [OUT_W-1:0] r_level;

    assign pulse_sum = PSUM_W'(i_pulse_one_level) + PSUM_W'(i_pulse_two_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_vld <= i_start;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r_done <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p_num <= PN_W'(pulse_sum) * PULSE_GAIN;
        r1_p_den <= PULSE_DEN_BASE + PD_W'(pulse_sum) * PULSE_DEN_STEP;
        r1_tri   <= ACC_W'(i_triangle_level) * TRI_WEIGHT;
        r1_noise <= ACC_W'(i_noise_level) * NOISE_WEIGHT;
        r1_dmc   <= ACC_W'(i_sample_channel_level) * DMC_WEIGHT;

        r2_p_num <= r1_p_num;
        r2_p_den <= r1_p_den;
        r2_acc   <= r1_tri + r1_noise + r1_dmc;

        r3_p_num <= r2_p_num;
        r3_p_den <= r2_p_den;
        r3_t_num <= TN_W'(r2_acc) * TND_GAIN;
        r3_t_den <= TND_DEN_BASE + TN_W'(r2_acc) * TND_DEN_STEP;

        r_level  <= n_level;
    end

    apumix_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_p_num (PD_W'(r3_p_num)),
        .i_p_den (r3_p_den),
        .i_t_num (r3_t_num),
        .i_t_den (r3_t_den),
        .o_vld   (div_vld),
        .o_p_quo (p_quo),
        .o_t_quo (t_quo)
    );

    always_comb begin
        rnd = EXT_W'(p_quo) + EXT_W'(t_quo) + RND_HALF;
        lvl = rnd[EXT_W-1:RND_SH];
        if (|lvl[EXT_W-RND_SH-1:OUT_W]) begin
            n_level = OUT_MAX;
        end else begin
            n_level = lvl[OUT_W-1:0];
        end
    end

    assign o_busy        = 1'b0;
    assign o_done        = r_done;
    assign o_mixed_level = r_level;

endmodule

[src/apumix_checker.sv]
module apumix_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [3:0]  i_pulse_one_level,
    input logic [3:0]  i_pulse_two_level,
    input logic [3:0]  i_triangle_level,
    input logic [3:0]  i_noise_level,
    input logic [6:0]  i_sample_channel_level,
    input logic        o_done,
    input logic [15:0] o_mixed_level
);
    import apumix_pkg::*;

    logic silent_word;

    assign silent_word = (i_pulse_one_level == 4'd0) && (i_pulse_two_level == 4'd0)
                      && (i_triangle_level == 4'd0) && (i_noise_level == 4'd0)
                      && (i_sample_channel_level == 7'd0);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("mixer raised busy");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result without an accepted word");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && silent_word) |-> ##LATENCY (o_mixed_level == 16'd0))
        else $error("silent word gave a nonzero mix");

endmodule

bind apu_nonlinear_mixer apumix_checker u_apumix_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_start                (i_start),
    .o_busy                 (o_busy),
    .i_pulse_one_level      (i_pulse_one_level),
    .i_pulse_two_level      (i_pulse_two_level),
    .i_triangle_level       (i_triangle_level),
    .i_noise_level          (i_noise_level),
    .i_sample_channel_level (i_sample_channel_level),
    .o_done                 (o_done),
    .o_mixed_level          (o_mixed_level)
);
